// File: sv/rmq_pkg.sv
// Shared types, constants and a width helper for the rotation matrix to quaternion block.
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int ELEM_W        = 16;
    localparam int Q_W           = 16;
    localparam int QBITS         = Q_W - 1;
    localparam logic [Q_W-1:0] Q_POS_SAT = 16'h7fff;
    localparam logic [Q_W-1:0] Q_NEG_SAT = 16'h8000;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_Y     = 2'd1,
        BR_Z     = 2'd2,
        BR_X     = 2'd3
    } br_t;

    typedef struct packed {
        br_t        br;
        logic       inv;
        logic [3:0] neg;
    } rmq_ctl_t;

    // signed width of pivot argument and off-diagonal terms
    function automatic int term_width(input int frac);
        return (frac + 3 > 18) ? frac + 3 : 18;
    endfunction

endpackage

// File: sv/rmq_front.sv
// Branch select, component terms, magnitudes, squares and sum of squares (three stages).
module rmq_front
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int VW = term_width(FRAC_BITS),
    localparam int MW = VW - 1,
    localparam int SW = 2 * MW + 2
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       ce,
    input  logic                       in_valid,
    input  logic signed [ELEM_W-1:0]   m00, m01, m02,
    input  logic signed [ELEM_W-1:0]   m10, m11, m12,
    input  logic signed [ELEM_W-1:0]   m20, m21, m22,
    output logic                       out_valid,
    output logic [SW-1:0]              out_sum,
    output logic [3:0][MW-1:0]         out_mag,
    output rmq_ctl_t                   out_ctl
);

    logic signed [VW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [VW-1:0] one_v, trace, a_v;
    logic signed [VW-1:0] v_next [4];
    br_t                  br_next;

    logic signed [VW-1:0] v_reg [4];
    br_t                  br_a_reg;
    logic                 inv_a_reg;
    logic                 valid_a_reg;

    logic [3:0][MW-1:0]   mag_next;
    logic [3:0]           neg_next;
    logic [3:0][MW-1:0]   mag_b_reg;
    logic [3:0][2*MW-1:0] sq_reg;
    rmq_ctl_t             ctl_b_reg;
    logic                 valid_b_reg;

    logic [SW-1:0]        sum_reg;
    logic [3:0][MW-1:0]   mag_c_reg;
    rmq_ctl_t             ctl_c_reg;
    logic                 valid_c_reg;

    assign e00 = VW'(m00);
    assign e01 = VW'(m01);
    assign e02 = VW'(m02);
    assign e10 = VW'(m10);
    assign e11 = VW'(m11);
    assign e12 = VW'(m12);
    assign e20 = VW'(m20);
    assign e21 = VW'(m21);
    assign e22 = VW'(m22);
    assign one_v = VW'(1) <<< FRAC_BITS;
    assign trace = e00 + e11 + e22;

    // pivot on the trace, else on the largest diagonal element
    always_comb begin
        priority if (!trace[VW-1]) begin
            br_next   = BR_TRACE;
            a_v       = one_v + trace;
            v_next[0] = a_v;
            v_next[1] = e12 - e21;
            v_next[2] = e20 - e02;
            v_next[3] = e01 - e10;
        end else if (m11 > m00 && m11 > m22) begin
            br_next   = BR_Y;
            a_v       = one_v - e00 + e11 - e22;
            v_next[0] = e20 - e02;
            v_next[1] = e10 + e01;
            v_next[2] = a_v;
            v_next[3] = e21 + e12;
        end else if (m22 > m00) begin
            br_next   = BR_Z;
            a_v       = one_v - e00 - e11 + e22;
            v_next[0] = e01 - e10;
            v_next[1] = e20 + e02;
            v_next[2] = e21 + e12;
            v_next[3] = a_v;
        end else begin
            br_next   = BR_X;
            a_v       = one_v + e00 - e11 - e22;
            v_next[0] = e12 - e21;
            v_next[1] = a_v;
            v_next[2] = e10 + e01;
            v_next[3] = e20 + e02;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            neg_next[i] = v_reg[i][VW-1];
            mag_next[i] = neg_next[i] ? MW'(-v_reg[i]) : MW'(v_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 4; i++) begin
                v_reg[i]  <= v_next[i];
                sq_reg[i] <= (2*MW)'(mag_next[i]) * (2*MW)'(mag_next[i]);
            end
            br_a_reg      <= br_next;
            inv_a_reg     <= a_v[VW-1] || (a_v == '0);
            mag_b_reg     <= mag_next;
            ctl_b_reg.br  <= br_a_reg;
            ctl_b_reg.inv <= inv_a_reg;
            ctl_b_reg.neg <= neg_next;
            sum_reg       <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]) + SW'(sq_reg[3]);
            mag_c_reg     <= mag_b_reg;
            ctl_c_reg     <= ctl_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end else if (ce) begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    assign out_valid = valid_c_reg;
    assign out_sum   = sum_reg;
    assign out_mag   = mag_c_reg;
    assign out_ctl   = ctl_c_reg;

endmodule

// File: sv/rmq_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module rmq_sqrt
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int VW = term_width(FRAC_BITS),
    localparam int MW = VW - 1,
    localparam int SW = 2 * MW + 2,
    localparam int RW = MW + 1,
    localparam int TW = 2 * RW + 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               ce,
    input  logic               in_valid,
    input  logic [SW-1:0]      in_sum,
    input  logic [3:0][MW-1:0] in_mag,
    input  rmq_ctl_t           in_ctl,
    output logic               out_valid,
    output logic [RW-1:0]      out_root,
    output logic [3:0][MW-1:0] out_mag,
    output rmq_ctl_t           out_ctl
);

    logic [TW-1:0]      rem_reg   [RW];
    logic [TW-1:0]      root_reg  [RW];
    logic [3:0][MW-1:0] mag_reg   [RW];
    rmq_ctl_t           ctl_reg   [RW];
    logic               valid_reg [RW];

    for (genvar j = 0; j < RW; j++) begin : g_step
        localparam int SH = RW - 1 - j;
        logic [TW-1:0]      rem_cur, root_cur, trial;
        logic [3:0][MW-1:0] mag_cur;
        rmq_ctl_t           ctl_cur;
        logic               valid_cur, take;

        if (j == 0) begin : g_first
            assign rem_cur   = TW'(in_sum);
            assign root_cur  = '0;
            assign mag_cur   = in_mag;
            assign ctl_cur   = in_ctl;
            assign valid_cur = in_valid;
        end else begin : g_next
            assign rem_cur   = rem_reg[j-1];
            assign root_cur  = root_reg[j-1];
            assign mag_cur   = mag_reg[j-1];
            assign ctl_cur   = ctl_reg[j-1];
            assign valid_cur = valid_reg[j-1];
        end

        // (root + 2^SH)^2 - root^2
        assign trial = (root_cur << (SH + 1)) + (TW'(1) << (2 * SH));
        assign take  = (rem_cur >= trial);

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[j]  <= take ? rem_cur - trial : rem_cur;
                root_reg[j] <= take ? (root_cur | (TW'(1) << SH)) : root_cur;
                mag_reg[j]  <= mag_cur;
                ctl_reg[j]  <= ctl_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (ce) begin
                valid_reg[j] <= valid_cur;
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign out_root  = RW'(root_reg[RW-1]);
    assign out_mag   = mag_reg[RW-1];
    assign out_ctl   = ctl_reg[RW-1];

endmodule

// File: sv/rmq_div.sv
// Rounded normalize: pipelined restoring division of each component by the root, then saturate.
module rmq_div
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int VW = term_width(FRAC_BITS),
    localparam int MW = VW - 1,
    localparam int RW = MW + 1,
    localparam int XW = MW + FRAC_BITS + 1,
    localparam int CW = ((XW > RW + Q_W) ? XW : RW + Q_W) + 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                ce,
    input  logic                in_valid,
    input  logic [RW-1:0]       in_root,
    input  logic [3:0][MW-1:0]  in_mag,
    input  rmq_ctl_t            in_ctl,
    output logic                out_valid,
    output logic [3:0][Q_W-1:0] out_q,
    output br_t                 out_br,
    output logic                out_inv
);

    // numerator = mag * ONE + root / 2
    logic [3:0][CW-1:0]    num_reg;
    logic [RW-1:0]         den_x_reg;
    rmq_ctl_t              ctl_x_reg;
    logic                  valid_x_reg;

    // quotient of 2^15 or more saturates
    logic [3:0][CW-1:0]    rem_o_reg;
    logic [3:0]            ovf_o_reg;
    logic [RW-1:0]         den_o_reg;
    rmq_ctl_t              ctl_o_reg;
    logic                  valid_o_reg;

    logic [3:0][CW-1:0]    rem_reg   [QBITS];
    logic [3:0][QBITS-1:0] quo_reg   [QBITS];
    logic [3:0]            ovf_reg   [QBITS];
    logic [RW-1:0]         den_reg   [QBITS];
    rmq_ctl_t              ctl_reg   [QBITS];
    logic                  valid_reg [QBITS];

    logic [3:0][Q_W-1:0]   q_reg;
    br_t                   br_reg;
    logic                  inv_reg;
    logic                  valid_out_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 4; i++) begin
                num_reg[i]   <= (CW'(in_mag[i]) << FRAC_BITS) + CW'(in_root >> 1);
                ovf_o_reg[i] <= (num_reg[i] >= (CW'(den_x_reg) << QBITS));
            end
            den_x_reg <= in_root;
            ctl_x_reg <= in_ctl;
            rem_o_reg <= num_reg;
            den_o_reg <= den_x_reg;
            ctl_o_reg <= ctl_x_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_x_reg <= 1'b0;
            valid_o_reg <= 1'b0;
        end else if (ce) begin
            valid_x_reg <= in_valid;
            valid_o_reg <= valid_x_reg;
        end
    end

    for (genvar j = 0; j < QBITS; j++) begin : g_step
        localparam int SH = QBITS - 1 - j;
        logic [3:0][CW-1:0]    rem_cur;
        logic [3:0][QBITS-1:0] quo_cur;
        logic [3:0]            ovf_cur;
        logic [RW-1:0]         den_cur;
        rmq_ctl_t              ctl_cur;
        logic                  valid_cur;
        logic [CW-1:0]         dsh;
        logic [3:0][CW-1:0]    rem_next;
        logic [3:0][QBITS-1:0] quo_next;

        if (j == 0) begin : g_first
            assign rem_cur   = rem_o_reg;
            assign quo_cur   = '0;
            assign ovf_cur   = ovf_o_reg;
            assign den_cur   = den_o_reg;
            assign ctl_cur   = ctl_o_reg;
            assign valid_cur = valid_o_reg;
        end else begin : g_next
            assign rem_cur   = rem_reg[j-1];
            assign quo_cur   = quo_reg[j-1];
            assign ovf_cur   = ovf_reg[j-1];
            assign den_cur   = den_reg[j-1];
            assign ctl_cur   = ctl_reg[j-1];
            assign valid_cur = valid_reg[j-1];
        end

        assign dsh = CW'(den_cur) << SH;

        always_comb begin
            for (int i = 0; i < 4; i++) begin
                rem_next[i] = rem_cur[i];
                quo_next[i] = quo_cur[i];
                if (rem_cur[i] >= dsh) begin
                    rem_next[i]     = rem_cur[i] - dsh;
                    quo_next[i][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[j] <= rem_next;
                quo_reg[j] <= quo_next;
                ovf_reg[j] <= ovf_cur;
                den_reg[j] <= den_cur;
                ctl_reg[j] <= ctl_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (ce) begin
                valid_reg[j] <= valid_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 4; i++) begin
                priority if (ctl_reg[QBITS-1].inv) begin
                    q_reg[i] <= '0;
                end else if (ovf_reg[QBITS-1][i]) begin
                    q_reg[i] <= ctl_reg[QBITS-1].neg[i] ? Q_NEG_SAT : Q_POS_SAT;
                end else if (ctl_reg[QBITS-1].neg[i]) begin
                    q_reg[i] <= -{1'b0, quo_reg[QBITS-1][i]};
                end else begin
                    q_reg[i] <= {1'b0, quo_reg[QBITS-1][i]};
                end
            end
            br_reg  <= ctl_reg[QBITS-1].br;
            inv_reg <= ctl_reg[QBITS-1].inv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_out_reg <= 1'b0;
        end else if (ce) begin
            valid_out_reg <= valid_reg[QBITS-1];
        end
    end

    assign out_valid = valid_out_reg;
    assign out_q     = q_reg;
    assign out_br    = br_reg;
    assign out_inv   = inv_reg;

endmodule

// File: sv/rotation_matrix_to_quaternion.sv
// Throughput: one matrix per cycle; the whole pipeline advances whenever the output
// register is empty or being taken, so a stall holds every stage in place.
// The depth is set by the bit-serial square root (one root bit per stage) and the
// restoring divider (one quotient bit per stage). Reset clears all valid bits.
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata: m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each, from bit 0 up)
    input  logic [143:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // m_tdata: q_w, q_x, q_y, q_z (16 bits each, from bit 0 up)
    output logic [63:0]  m_tdata,
    // m_tuser: branch_taken [1:0], invalid [2]
    output logic [2:0]   m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready
);

    localparam int VW = term_width(FRAC_BITS);
    localparam int MW = VW - 1;
    localparam int SW = 2 * MW + 2;
    localparam int RW = MW + 1;

    logic                pipe_adv;
    logic                f_valid, r_valid, d_valid;
    logic [SW-1:0]       f_sum;
    logic [3:0][MW-1:0]  f_mag, r_mag;
    rmq_ctl_t            f_ctl, r_ctl;
    logic [RW-1:0]       r_root;
    logic [3:0][Q_W-1:0] d_q;
    br_t                 d_br;
    logic                d_inv;

    // advance when the result register is free or its transfer completes
    assign pipe_adv = !d_valid || m_tready;
    assign s_tready = pipe_adv;

    rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (pipe_adv),
        .in_valid  (s_tvalid),
        .m00       (s_tdata[15:0]),
        .m01       (s_tdata[31:16]),
        .m02       (s_tdata[47:32]),
        .m10       (s_tdata[63:48]),
        .m11       (s_tdata[79:64]),
        .m12       (s_tdata[95:80]),
        .m20       (s_tdata[111:96]),
        .m21       (s_tdata[127:112]),
        .m22       (s_tdata[143:128]),
        .out_valid (f_valid),
        .out_sum   (f_sum),
        .out_mag   (f_mag),
        .out_ctl   (f_ctl)
    );

    rmq_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (pipe_adv),
        .in_valid  (f_valid),
        .in_sum    (f_sum),
        .in_mag    (f_mag),
        .in_ctl    (f_ctl),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_mag   (r_mag),
        .out_ctl   (r_ctl)
    );

    rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (pipe_adv),
        .in_valid  (r_valid),
        .in_root   (r_root),
        .in_mag    (r_mag),
        .in_ctl    (r_ctl),
        .out_valid (d_valid),
        .out_q     (d_q),
        .out_br    (d_br),
        .out_inv   (d_inv)
    );

    assign m_tvalid = d_valid;
    assign m_tdata  = {d_q[3], d_q[2], d_q[1], d_q[0]};
    assign m_tuser  = {d_inv, d_br};

endmodule

// File: bench/rotation_matrix_to_quaternion_tb.sv
// Self-checking testbench for the rotation matrix to quaternion block.
module rotation_matrix_to_quaternion_tb;
    import rmq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int LATENCY = 3 + ((FRAC + 3 > 18) ? FRAC + 3 : 18) + 18;
    localparam int WATCHDOG = 20000;

    typedef struct {
        logic signed [15:0] qw, qx, qy, qz;
        br_t                br;
        logic               inv;
    } quat_t;

    class quat_scoreboard;
        quat_t pending[$];
        int    errors;

        function automatic longint unsigned sqrt_floor(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function automatic logic signed [15:0] scale(longint v, longint unsigned n);
            longint unsigned mag, q;
            longint s;
            mag = (v < 0) ? -v : v;
            q = (mag * (64'd1 << FRAC) + n / 2) / n;
            if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
            s = (v < 0) ? -longint'(q) : longint'(q);
            if (s < -32768) s = -32768;
            if (s > 32767) s = 32767;
            return s[15:0];
        endfunction

        function void note_matrix(logic [143:0] d);
            longint m[9];
            longint v[4];
            longint one, t, a;
            longint unsigned sq, n;
            quat_t e;
            for (int i = 0; i < 9; i++) m[i] = longint'($signed(d[16*i +: 16]));
            one = 64'sd1 << FRAC;
            t = m[0] + m[4] + m[8];
            if (t >= 0) begin
                e.br = BR_TRACE;
                a = one + t;
                v = '{a, m[5] - m[7], m[6] - m[2], m[1] - m[3]};
            end else if (m[4] > m[0] && m[4] > m[8]) begin
                e.br = BR_Y;
                a = one - m[0] + m[4] - m[8];
                v = '{m[6] - m[2], m[3] + m[1], a, m[7] + m[5]};
            end else if (m[8] > m[0]) begin
                e.br = BR_Z;
                a = one - m[0] - m[4] + m[8];
                v = '{m[1] - m[3], m[6] + m[2], m[7] + m[5], a};
            end else begin
                e.br = BR_X;
                a = one + m[0] - m[4] - m[8];
                v = '{m[5] - m[7], a, m[3] + m[1], m[6] + m[2]};
            end
            if (a <= 0) begin
                e.inv = 1'b1;
                e.qw = '0; e.qx = '0; e.qy = '0; e.qz = '0;
            end else begin
                sq = 0;
                for (int i = 0; i < 4; i++) sq += v[i] * v[i];
                n = sqrt_floor(sq);
                if (n == 0) n = 1;
                e.inv = 1'b0;
                e.qw = scale(v[0], n); e.qx = scale(v[1], n);
                e.qy = scale(v[2], n); e.qz = scale(v[3], n);
            end
            pending.insert(pending.size(), e);
        endfunction

        function void check_quat(logic [63:0] d, logic [2:0] u);
            quat_t e;
            if (pending.size() == 0) begin
                $error("unexpected result tdata=%h tuser=%h", d, u);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[15:0] !== e.qw) begin
                $error("q_w expected %0d got %0d", e.qw, $signed(d[15:0])); errors++;
            end
            if (d[31:16] !== e.qx) begin
                $error("q_x expected %0d got %0d", e.qx, $signed(d[31:16])); errors++;
            end
            if (d[47:32] !== e.qy) begin
                $error("q_y expected %0d got %0d", e.qy, $signed(d[47:32])); errors++;
            end
            if (d[63:48] !== e.qz) begin
                $error("q_z expected %0d got %0d", e.qz, $signed(d[63:48])); errors++;
            end
            if (u[1:0] !== e.br) begin
                $error("branch_taken expected %0d got %0d", e.br, u[1:0]); errors++;
            end
            if (u[2] !== e.inv) begin
                $error("invalid expected %0d got %0d", e.inv, u[2]); errors++;
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic [143:0] s_tdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tvalid;
    logic         m_tready;

    quat_scoreboard sb;
    int  send_idle_pct, recv_idle_pct;
    bit  recv_hold;
    int  idle_cycles;

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Track transfers at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_matrix(s_tdata);
            if (m_tvalid && m_tready) sb.check_quat(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || sb.pending.size() == 0)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        if (recv_hold) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_matrix(logic [143:0] d);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    function automatic logic [143:0] pack_mat(int e[9]);
        logic [143:0] d;
        for (int i = 0; i < 9; i++) d[16*i +: 16] = 16'(e[i]);
        return d;
    endfunction

    function automatic int rand_elem();
        case ($urandom_range(5))
            0: return -16384;
            1: return 16384;
            2: return 0;
            default: return int'($urandom_range(32768)) - 16384;
        endcase
    endfunction

    // Proper rotation from a random quaternion, rounded to Q2.14.
    function automatic logic [143:0] rand_rotation();
        real w, x, y, z, l, r[9];
        int e[9];
        w = $urandom_range(2000) - 1000.0; x = $urandom_range(2000) - 1000.0;
        y = $urandom_range(2000) - 1000.0; z = $urandom_range(2000) - 1000.0;
        l = $sqrt(w*w + x*x + y*y + z*z);
        if (l < 1.0) begin
            w = 1.0; l = 1.0;
        end
        w /= l; x /= l; y /= l; z /= l;
        r = '{1 - 2*(y*y + z*z), 2*(x*y + w*z), 2*(x*z - w*y),
              2*(x*y - w*z), 1 - 2*(x*x + z*z), 2*(y*z + w*x),
              2*(x*z + w*y), 2*(y*z - w*x), 1 - 2*(x*x + y*y)};
        for (int i = 0; i < 9; i++) begin
            e[i] = $rtoi(r[i] * 16384.0 + (r[i] >= 0 ? 0.5 : -0.5));
            if (e[i] > 16384) e[i] = 16384;
            if (e[i] < -16384) e[i] = -16384;
        end
        return pack_mat(e);
    endfunction

    function automatic logic [143:0] rand_matrix();
        int e[9];
        if ($urandom_range(99) < 70) return rand_rotation();
        for (int i = 0; i < 9; i++) e[i] = rand_elem();
        return pack_mat(e);
    endfunction

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        recv_hold = 1'b0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: identity, each pivot and extremes.
        send_matrix(pack_mat('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}));
        send_matrix(pack_mat('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}));
        send_matrix(pack_mat('{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}));
        send_matrix(pack_mat('{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}));
        send_matrix(pack_mat('{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}));
        send_matrix(pack_mat('{-16384, 16384, -16384, 16384, -16384, 16384,
                               -16384, 16384, -16384}));
        send_matrix(pack_mat('{16384, 16384, 16384, 16384, 16384, 16384,
                               16384, 16384, 16384}));
        send_matrix(pack_mat('{0, 16384, -16384, -16384, 0, 16384, 16384, -16384, 0}));
        send_matrix(pack_mat('{-16384, -16384, -16384, -16384, -16384, -16384,
                               -16384, -16384, -16384}));
        send_matrix(pack_mat('{-5000, 300, 0, 0, -5000, 0, 0, 0, -5000}));
        send_matrix(pack_mat('{-16384, 0, 0, 0, -8000, 0, 0, 0, -8000}));
        send_matrix(pack_mat('{-8000, 0, 0, 0, -16384, 0, 0, 0, -8000}));
        send_matrix(pack_mat('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
        send_matrix(pack_mat('{0, -16384, 16384, 16384, 0, -16384, -16384, 16384, 0}));
        drop_valid();

        // Long receiver hold: pipeline fills and back-pressures input.
        recv_hold = 1'b1;
        fork
            begin
                repeat (150) @(posedge aclk);
                recv_hold = 1'b0;
            end
            for (int i = 0; i < 70; i++) send_matrix(rand_matrix());
        join
        drop_valid();
        wait_drained();

        send_idle_pct = 28; recv_idle_pct = 73;
        for (int i = 0; i < 320; i++) send_matrix(rand_matrix());
        send_idle_pct = 73; recv_idle_pct = 28;
        for (int i = 0; i < 320; i++) send_matrix(rand_matrix());
        send_idle_pct = 0; recv_idle_pct = 0;
        for (int i = 0; i < 330; i++) send_matrix(rand_matrix());
        drop_valid();

        wait_drained();
        repeat (LATENCY + 10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
